// ===== rtl/aoc_pkg.sv =====
// ----------------------------------------------------------------------------
// aoc_pkg
// Shared types and constants of the angular obstacle clusterer.
// ----------------------------------------------------------------------------
package aoc_pkg;

    localparam int ANGLE_W = 16;
    localparam int GAP_W   = 15;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 15;

    // configuration register indexes
    localparam logic [0:0] CFG_MAX_GAP   = 1'b0;
    localparam logic [0:0] CFG_MIN_COUNT = 1'b1;

    // reset values: 10 degrees in 1/64 degree, four features
    localparam logic [GAP_W-1:0]   MAX_GAP_RESET   = 15'd640;
    localparam logic [COUNT_W-1:0] MIN_COUNT_RESET = 8'd4;

    // smallest run that is ever reported
    localparam logic [COUNT_W-1:0] MIN_COUNT_FLOOR = 8'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;

    typedef struct packed {
        logic [GAP_W-1:0]   max_gap;
        logic [COUNT_W-1:0] min_count;
    } cfg_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] left_edge;
        logic signed [ANGLE_W-1:0] right_edge;
        logic signed [ANGLE_W-1:0] center;
        logic [COUNT_W-1:0]        feature_count;
    } result_t;

endpackage

// ===== rtl/angular_obstacle_clusterer.sv =====
// ----------------------------------------------------------------------------
// angular_obstacle_clusterer
// Groups a stream of feature angles into obstacles separated by angle gaps.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one feature angle per item (1/64 degree, signed) plus a
//     frame_last flag on the final feature of a scan
//   m_ channel: one item per reported obstacle with left and right edge,
//     floored center and feature count
//   cfg_ channel: index 0 writes max_gap, index 1 writes min_count; always
//     ready, write only while the block is idle
// timing:
//   an accepted item lands in the input register; once the result buffer
//   has room the run logic updates state and any result is loaded into the
//   output register, or the spare entry while the output is held
//   one item per cycle sustained while the buffer has room; the gap test,
//   counter and edge sum are a single short path, input to result register
// reset:
//   synchronous, active low; clears the open run, both buffers and restores
//   max_gap to 640 (10 degrees) and min_count to 4
// stall:
//   a two-entry result buffer absorbs a stalled receiver; s_ready drops only
//   once that buffer is full and the input register holds an item
// ----------------------------------------------------------------------------
module angular_obstacle_clusterer (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // feature input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [aoc_pkg::ANGLE_W-1:0]   s_angle,
    input  logic                                 s_frame_last,

    // obstacle output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [aoc_pkg::ANGLE_W-1:0]   m_left_edge,
    output logic signed [aoc_pkg::ANGLE_W-1:0]   m_right_edge,
    output logic signed [aoc_pkg::ANGLE_W-1:0]   m_center,
    output logic [aoc_pkg::COUNT_W-1:0]          m_feature_count,

    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [0:0]                           cfg_index,
    input  logic [aoc_pkg::CFG_W-1:0]            cfg_data
);

    // configuration registers
    logic [aoc_pkg::GAP_W-1:0]           max_gap_reg;
    logic [aoc_pkg::COUNT_W-1:0]         min_count_reg;
    aoc_pkg::cfg_t                       cfg;

    // input register
    logic                                in_valid_reg;
    logic signed [aoc_pkg::ANGLE_W-1:0]  in_angle_reg;
    logic                                in_last_reg;

    // stage handshake
    logic                                advance;
    logic                                skid_ready;
    logic                                emit;
    aoc_pkg::result_t                    result;
    aoc_pkg::result_t                    out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_gap_reg   <= aoc_pkg::MAX_GAP_RESET;
            min_count_reg <= aoc_pkg::MIN_COUNT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                aoc_pkg::CFG_MAX_GAP: begin
                    max_gap_reg <= cfg_data;
                end
                aoc_pkg::CFG_MIN_COUNT: begin
                    min_count_reg <= cfg_data[aoc_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.max_gap   = max_gap_reg;
    assign cfg.min_count = min_count_reg;

    // the held item moves on once the result buffer has room
    assign advance = in_valid_reg && skid_ready;
    assign s_ready = !in_valid_reg || skid_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_angle_reg <= s_angle;
            in_last_reg  <= s_frame_last;
        end
    end

    // run state and obstacle math
    aoc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .angle      (in_angle_reg),
        .frame_last (in_last_reg),
        .cfg        (cfg),
        .emit       (emit),
        .result     (result)
    );

    // result register with spare entry
    aoc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (advance && emit),
        .in_ready  (skid_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_left_edge     = out_data.left_edge;
    assign m_right_edge    = out_data.right_edge;
    assign m_center        = out_data.center;
    assign m_feature_count = out_data.feature_count;

    // input stalls only when the result side is really backed up
    a_stall_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low while no result is pending");

    // a reported obstacle always holds at least two features
    a_count_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_feature_count >= aoc_pkg::MIN_COUNT_FLOOR))
        else $error("obstacle reported with fewer than two features");

    // reset empties the result buffer
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a result leaves only from an item that was in the input register
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_valid_reg))
        else $error("result appeared without a held item");

endmodule

// ===== rtl/aoc_core.sv =====
// ----------------------------------------------------------------------------
// aoc_core
// Run tracking state and the per-item gap test, edge and center logic.
// ----------------------------------------------------------------------------
module aoc_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step,
    input  logic signed [aoc_pkg::ANGLE_W-1:0]   angle,
    input  logic                                 frame_last,
    input  aoc_pkg::cfg_t                        cfg,
    output logic                                 emit,
    output aoc_pkg::result_t                     result
);

    logic                                have_previous_reg, have_previous_next;
    logic signed [aoc_pkg::ANGLE_W-1:0]  previous_angle_reg, previous_angle_next;
    logic signed [aoc_pkg::ANGLE_W-1:0]  run_left_reg, run_left_next;
    logic [aoc_pkg::COUNT_W-1:0]         run_count_reg, run_count_next;

    logic signed [aoc_pkg::ANGLE_W+1:0]  step_diff;
    logic signed [aoc_pkg::ANGLE_W+1:0]  gap_limit;
    logic                                extend;
    logic [aoc_pkg::COUNT_W-1:0]         need;
    logic signed [aoc_pkg::ANGLE_W-1:0]  left_upd;
    logic [aoc_pkg::COUNT_W-1:0]         count_upd;
    logic                                gap_emit;
    logic                                last_emit;
    logic signed [aoc_pkg::ANGLE_W-1:0]  res_left;
    logic signed [aoc_pkg::ANGLE_W-1:0]  res_right;
    logic signed [aoc_pkg::ANGLE_W:0]    edge_sum;

    // step is new minus previous, widened so it cannot wrap
    assign step_diff = {{2{angle[aoc_pkg::ANGLE_W-1]}}, angle}
                     - {{2{previous_angle_reg[aoc_pkg::ANGLE_W-1]}}, previous_angle_reg};
    assign gap_limit = {3'b000, cfg.max_gap};
    assign extend    = have_previous_reg && (step_diff <= gap_limit);

    assign need = (cfg.min_count < aoc_pkg::MIN_COUNT_FLOOR) ? aoc_pkg::MIN_COUNT_FLOOR
                                                             : cfg.min_count;

    always_comb begin
        if (extend) begin
            left_upd  = run_left_reg;
            count_upd = (run_count_reg == aoc_pkg::COUNT_MAX) ? run_count_reg
                                                               : run_count_reg + 8'd1;
        end else begin
            left_upd  = angle;
            count_upd = 8'd1;
        end
    end

    // a gap closes the old run at the previous angle
    assign gap_emit  = !extend && have_previous_reg && (run_count_reg >= need);
    // the last item closes the open run at this angle
    assign last_emit = frame_last && !gap_emit && (count_upd >= need);
    assign emit      = gap_emit || last_emit;

    assign res_left  = gap_emit ? run_left_reg       : left_upd;
    assign res_right = gap_emit ? previous_angle_reg : angle;
    assign edge_sum  = {res_left[aoc_pkg::ANGLE_W-1], res_left}
                     + {res_right[aoc_pkg::ANGLE_W-1], res_right};

    always_comb begin
        result.left_edge     = res_left;
        result.right_edge    = res_right;
        result.center        = edge_sum[aoc_pkg::ANGLE_W:1];   // floor of half
        result.feature_count = gap_emit ? run_count_reg : count_upd;
    end

    always_comb begin
        if (frame_last) begin
            have_previous_next  = 1'b0;
            previous_angle_next = '0;
            run_left_next       = '0;
            run_count_next      = '0;
        end else begin
            have_previous_next  = 1'b1;
            previous_angle_next = angle;
            run_left_next       = left_upd;
            run_count_next      = count_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_previous_reg  <= 1'b0;
            previous_angle_reg <= '0;
            run_left_reg       <= '0;
            run_count_reg      <= '0;
        end else if (step) begin
            have_previous_reg  <= have_previous_next;
            previous_angle_reg <= previous_angle_next;
            run_left_reg       <= run_left_next;
            run_count_reg      <= run_count_next;
        end
    end

endmodule

// ===== rtl/aoc_skid.sv =====
// ----------------------------------------------------------------------------
// aoc_skid
// Two-entry result buffer: output register plus one spare entry.
// ----------------------------------------------------------------------------
module aoc_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  aoc_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aoc_pkg::result_t  out_data
);

    logic              out_valid_reg;
    logic              spare_valid_reg;
    aoc_pkg::result_t  out_data_reg;
    aoc_pkg::result_t  spare_data_reg;
    logic              pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !spare_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (spare_valid_reg) begin
            if (pop) begin
                out_valid_reg   <= 1'b1;
                spare_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                spare_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (spare_valid_reg) begin
            if (pop) begin
                out_data_reg <= spare_data_reg;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= in_data;
            end else begin
                spare_data_reg <= in_data;
            end
        end
    end

endmodule

// ===== test/tb_angular_obstacle_clusterer.sv =====
// ----------------------------------------------------------------------------
// tb_angular_obstacle_clusterer
// Self-checking bench: feeds scans of feature angles through the clusterer
// under random idling and stalls, predicts every obstacle and compares each
// reported one field by field, across several max_gap/min_count settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// tracks the open run the way the block does and queues the obstacles it owes
class obstacle_scoreboard;
    logic [aoc_pkg::GAP_W-1:0]          max_gap;
    logic [aoc_pkg::COUNT_W-1:0]        min_count;
    bit                                 run_open;
    logic signed [aoc_pkg::ANGLE_W-1:0] last_angle;
    logic signed [aoc_pkg::ANGLE_W-1:0] run_left;
    logic [aoc_pkg::COUNT_W-1:0]        run_count;
    aoc_pkg::result_t                   owed_q[$];
    int                                 errors;

    function new();
        max_gap    = aoc_pkg::MAX_GAP_RESET;
        min_count  = aoc_pkg::MIN_COUNT_RESET;
        run_open   = 1'b0;
        last_angle = '0;
        run_left   = '0;
        run_count  = '0;
        errors     = 0;
    endfunction

    function void write_register(logic [0:0] index, logic [aoc_pkg::CFG_W-1:0] data);
        case (index)
            aoc_pkg::CFG_MAX_GAP:   max_gap   = data[aoc_pkg::GAP_W-1:0];
            aoc_pkg::CFG_MIN_COUNT: min_count = data[aoc_pkg::COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    // closes the open run at the given right edge; 1 if it is big enough
    function bit close_run(logic signed [aoc_pkg::ANGLE_W-1:0] right,
                           output aoc_pkg::result_t r);
        int need;
        int total;
        need  = (min_count < aoc_pkg::MIN_COUNT_FLOOR) ? aoc_pkg::MIN_COUNT_FLOOR
                                                       : min_count;
        r     = '0;
        if (run_count < need) return 1'b0;
        total = int'(run_left) + int'(right);
        r.left_edge     = run_left;
        r.right_edge    = right;
        r.center        = 16'(total >>> 1);
        r.feature_count = run_count;
        return 1'b1;
    endfunction

    function void note_feature(logic signed [aoc_pkg::ANGLE_W-1:0] angle, logic last);
        int               step;
        bit               owed;
        aoc_pkg::result_t r;
        owed = 1'b0;
        step = int'(angle) - int'(last_angle);
        if (run_open && step <= int'(max_gap)) begin
            if (run_count != aoc_pkg::COUNT_MAX) run_count++;
        end else begin
            if (run_open) owed = close_run(last_angle, r);
            run_left  = angle;
            run_count = 8'd1;
        end
        last_angle = angle;
        run_open   = 1'b1;
        if (last) begin
            if (!owed) owed = close_run(angle, r);
            run_open   = 1'b0;
            last_angle = '0;
            run_left   = '0;
            run_count  = '0;
        end
        if (owed) owed_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
        if (errors < 40) $display("mismatch: %s", msg);
        else if (errors == 40) $display("mismatch: further ones not shown");
        errors++;
    endtask

    task check_obstacle(aoc_pkg::result_t seen);
        aoc_pkg::result_t want;
        if (owed_q.size() == 0) begin
            report_mismatch($sformatf("obstacle with no prediction, left %0d right %0d",
                                      seen.left_edge, seen.right_edge));
        end else begin
            want = owed_q.pop_front();
            if (seen.left_edge !== want.left_edge)
                report_mismatch($sformatf("left_edge %0d, predicted %0d",
                                          seen.left_edge, want.left_edge));
            if (seen.right_edge !== want.right_edge)
                report_mismatch($sformatf("right_edge %0d, predicted %0d",
                                          seen.right_edge, want.right_edge));
            if (seen.center !== want.center)
                report_mismatch($sformatf("center %0d, predicted %0d",
                                          seen.center, want.center));
            if (seen.feature_count !== want.feature_count)
                report_mismatch($sformatf("feature_count %0d, predicted %0d",
                                          seen.feature_count, want.feature_count));
        end
    endtask

    function int pending();
        return owed_q.size();
    endfunction
endclass

module tb_angular_obstacle_clusterer;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 8;    // two register stages plus margin
    localparam int TAIL_CYCLES     = 20;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 10;

    logic                                aclk         = 1'b0;
    logic                                aresetn      = 1'b0;
    logic                                s_valid      = 1'b0;
    logic                                s_ready;
    logic signed [aoc_pkg::ANGLE_W-1:0]  s_angle      = '0;
    logic                                s_frame_last = 1'b0;
    logic                                m_valid;
    logic                                m_ready      = 1'b0;
    logic signed [aoc_pkg::ANGLE_W-1:0]  m_left_edge;
    logic signed [aoc_pkg::ANGLE_W-1:0]  m_right_edge;
    logic signed [aoc_pkg::ANGLE_W-1:0]  m_center;
    logic [aoc_pkg::COUNT_W-1:0]         m_feature_count;
    logic                                cfg_valid    = 1'b0;
    logic                                cfg_ready;
    logic [0:0]                          cfg_index    = aoc_pkg::CFG_MAX_GAP;
    logic [aoc_pkg::CFG_W-1:0]           cfg_data     = '0;

    obstacle_scoreboard sb = new();

    // shaping knobs for the stimulus, mirrors of what was last written
    int  cur_gap     = aoc_pkg::MAX_GAP_RESET;
    int  cur_min     = aoc_pkg::MIN_COUNT_RESET;
    bit  quiet_src   = 1'b0;
    bit  quiet_sink  = 1'b0;
    int  sink_hold   = 0;
    int  cycles      = 0;
    int  phase_fed;

    angular_obstacle_clusterer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_angle         (s_angle),
        .s_frame_last    (s_frame_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_edge     (m_left_edge),
        .m_right_edge    (m_right_edge),
        .m_center        (m_center),
        .m_feature_count (m_feature_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // handshake monitor; values read here are the ones from before the edge
    always @(posedge aclk) begin
        aoc_pkg::result_t seen;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_feature(s_angle, s_frame_last);
            if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
            if (m_valid && m_ready) begin
                seen.left_edge     = m_left_edge;
                seen.right_edge    = m_right_edge;
                seen.center        = m_center;
                seen.feature_count = m_feature_count;
                sb.check_obstacle(seen);
            end
        end
    end

    // receiver: after each taken item, hold ready low for a drawn count
    always @(posedge aclk) begin
        int hold;
        if (m_ready) begin
            if (m_valid) begin
                hold = quiet_sink ? 0 : $urandom_range(0, 19);
                if (hold != 0) begin
                    m_ready   <= 1'b0;
                    sink_hold <= hold;
                end
            end
        end else if (sink_hold <= 1) begin
            m_ready   <= 1'b1;
            sink_hold <= 0;
        end else begin
            sink_hold <= sink_hold - 1;
        end
    end

    // one item on the feature channel; valid stays up when no gap is drawn
    task automatic send_feature(input logic signed [aoc_pkg::ANGLE_W-1:0] angle,
                                input logic last);
        int gap;
        gap = quiet_src ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_angle      <= angle;
        s_frame_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        phase_fed++;
    endtask

    task automatic cfg_write(input logic [0:0] index,
                             input logic [aoc_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // drain the block: all owed obstacles out, then let in-flight items die out
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(input int gap, input int min);
        settle();
        cfg_write(aoc_pkg::CFG_MAX_GAP, gap[aoc_pkg::CFG_W-1:0]);
        // upper data bits are don't-care for min_count, so randomize them
        cfg_write(aoc_pkg::CFG_MIN_COUNT, {7'($urandom_range(0, 127)), 8'(min)});
        cfg_valid <= 1'b0;
        cur_gap = gap;
        cur_min = min;
    endtask

    function automatic int wrap16(input int v);
        logic signed [aoc_pkg::ANGLE_W-1:0] a;
        a = v[aoc_pkg::ANGLE_W-1:0];
        return a;
    endfunction

    // step that stays inside a run: anywhere in range, exactly max, or backward
    function automatic int run_step();
        case ($urandom_range(0, 7))
            0:       return cur_gap;
            1:       return -$urandom_range(1, 200);
            default: return $urandom_range(0, cur_gap);
        endcase
    endfunction

    function automatic int gap_step();
        if ($urandom_range(0, 3) == 0) return cur_gap + 1;
        return cur_gap + 1 + $urandom_range(0, 2000);
    endfunction

    // well-formed scan: a few clusters split by gaps, usually closed by frame_last
    task automatic play_scan();
        int clusters, size, need, pos;
        bit close;
        quiet_src  = ($urandom_range(0, 4) == 0);
        quiet_sink = ($urandom_range(0, 4) == 0);
        close      = ($urandom_range(0, 9) != 0);
        clusters   = $urandom_range(1, 4);
        need       = (cur_min < 2) ? 2 : cur_min;
        pos        = int'($urandom_range(0, 65535)) - 32768;
        for (int c = 0; c < clusters; c++) begin
            size = (need > 12) ? $urandom_range(1, 8) : $urandom_range(1, need + 3);
            for (int k = 0; k < size; k++) begin
                if (k > 0) pos = wrap16(pos + run_step());
                else if (c > 0) pos = wrap16(pos + gap_step());
                send_feature(16'(pos), close && c == clusters - 1 && k == size - 1);
            end
        end
    endtask

    // noise: arbitrary angles with frame_last at random
    task automatic play_noise();
        int size;
        size = $urandom_range(1, 10);
        for (int k = 0; k < size; k++)
            send_feature(16'($urandom_range(0, 65535)), ($urandom_range(0, 2) == 0));
    endtask

    // long tight run from the bottom of the range; closed by a gap or by frame_last
    task automatic play_long_run(input int n, input bit gap_end);
        int pos;
        pos = -32768;
        for (int k = 0; k < n; k++) begin
            if (k > 0) pos = pos + $urandom_range(0, 3);
            send_feature(16'(pos), !gap_end && k == n - 1);
        end
        // step from below -31700 to the top is larger than any max_gap
        if (gap_end) send_feature(16'sh7fff, 1'b1);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset settings (max_gap 640, min_count 4)
        // exact max step, backward step, run of four closed by a gap
        send_feature(-16'sd32768, 1'b0);
        send_feature(-16'sd32128, 1'b0);
        send_feature(-16'sd32200, 1'b0);
        send_feature(-16'sd31560, 1'b0);
        send_feature(16'sd0, 1'b0);
        // step of max_gap + 1 leaves a single feature behind
        send_feature(16'sd641, 1'b0);
        send_feature(16'sd700, 1'b0);
        send_feature(16'sd701, 1'b0);
        send_feature(16'sd1341, 1'b0);
        // gap on the last item: old run reported, lone new one dropped
        send_feature(16'sd32767, 1'b1);
        // lone feature scan right after a close
        send_feature(16'sd5, 1'b1);
        // run from negative angles, left open here
        send_feature(-16'sd3, 1'b0);
        send_feature(-16'sd2, 1'b0);
        send_feature(-16'sd1, 1'b0);
        send_feature(16'sd0, 1'b0);
        // small step, so these three extend that run up to frame_last; then a run of four closed at the end
        send_feature(16'sd100, 1'b0);
        send_feature(16'sd101, 1'b0);
        send_feature(16'sd102, 1'b1);
        send_feature(16'sd2000, 1'b0);
        send_feature(16'sd2001, 1'b0);
        send_feature(16'sd2002, 1'b0);
        send_feature(16'sd2003, 1'b1);
        // wrap from +max to -max is a huge backward step, so the run goes on
        send_feature(16'sd32000, 1'b0);
        send_feature(16'sd32767, 1'b0);
        send_feature(-16'sd32768, 1'b0);
        send_feature(-16'sd32767, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: apply_setting(0, 2);
                1: apply_setting(32767, 255);
                2: apply_setting(1, 1);      // below the floor, acts as two
                3: apply_setting(12, 0);
                4: apply_setting(640, 4);
                default: apply_setting(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                                    : $urandom_range(0, 1500),
                                       ($urandom_range(0, 5) == 0) ? $urandom_range(11, 40)
                                                                   : $urandom_range(2, 10));
            endcase
            phase_fed = 0;
            if (cur_min == 255) begin
                // exactly 255 ended by a gap, then a saturating run
                play_long_run(255, 1'b1);
                play_long_run(270, 1'b0);
            end
            while (phase_fed < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 5) == 0) play_noise();
                else play_scan();
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/aoc_pkg.sv
rtl/aoc_core.sv
rtl/aoc_skid.sv
rtl/angular_obstacle_clusterer.sv
test/tb_angular_obstacle_clusterer.sv
